// ===== hw/rtl/psqm_pkg.sv =====
// Shared constants for the periodic spend quota meter.
// Status codes, register indexes and stream packing widths.
// No dependencies.
package psqm_pkg;

	// timestamp and cap width
	localparam int TS_W = 64;

	// stream packing
	localparam int MOD_W       = 16;
	localparam int IN_DATA_W   = 144; // module_num, amount, now_time
	localparam int OUT_DATA_W  = 136; // status, spent_total_now, spent_period_now, pad
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SCOPE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_YET   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_METERED       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_ACT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_PER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ORIGIN = 3'd6;

endpackage

// ===== hw/rtl/periodic_spend_quota_meter.sv =====
// Top level of the periodic spend quota meter.
// Uses psqm_pkg for status codes, register indexes and packing widths.
//
// Usage:
//   s_* stream takes one request: tdata = module_num, amount, now_time;
//   tuser = action (0 check, 1 check and charge).
//   m_* stream returns one result per request: tdata = status,
//   spent_total_now, spent_period_now.
//   cfg_* channel writes one configuration register per request; it is
//   always ready and is to be used only while no request is in flight.
//   Writing period_origin also reloads the running period start.
// Sequencing:
//   A request is worked on alone; s_tready is low from acceptance until
//   the result is placed in the output register. After the scope step,
//   scope and unmetered outcomes go to the final step, a time before a
//   set period's start via the roll check, metered ones via the roll check
//   and sum step; a roll adds, before the sum, the remainder of elapsed
//   time by period length, one bit a cycle in a shared subtract/compare
//   unit. The next request is taken the cycle after the result is stored.
// Reset clears sequencer, configuration, spends, period start and m_tvalid.
// A stalled receiver holds the result; a following request may still be
// taken and then waits in its last step until the output register frees.
module periodic_spend_quota_meter #(
	parameter int AMOUNT_WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// module_num[15:0], amount[79:16], now_time[143:80]
	input  logic [psqm_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[0]
	input  logic                             s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], spent_total_now[66:3], spent_period_now[130:67], zero[135:131]
	output logic [psqm_pkg::OUT_DATA_W-1:0]  m_tdata,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psqm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psqm_pkg::TS_W-1:0]        cfg_data
);
	import psqm_pkg::*;

	localparam int AW    = AMOUNT_WIDTH;
	localparam int CNT_W = $clog2(TS_W);

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCOPE   = 3'd1;
	localparam logic [2:0] S_ROLLCHK = 3'd2;
	localparam logic [2:0] S_DIV     = 3'd3;
	localparam logic [2:0] S_SUM     = 3'd4;
	localparam logic [2:0] S_FIN     = 3'd5;

	logic [2:0] state_q;

	// configuration
	logic [TS_W-1:0] module_mask_q;
	logic            metered_q;
	logic [TS_W-1:0] max_per_act_q;
	logic [TS_W-1:0] max_total_q;
	logic [TS_W-1:0] max_per_per_q;
	logic [TS_W-1:0] period_len_q;

	// metering state
	logic [AW-1:0]   spent_total_q;
	logic [AW-1:0]   spent_period_q;
	logic [TS_W-1:0] period_start_q;

	// request in flight
	logic            action_q;
	logic [MOD_W-1:0] mod_q;
	logic [AW-1:0]   amount_q;
	logic [TS_W-1:0] now_q;
	logic            decided_q;
	logic [STATUS_W-1:0] status_q;
	logic            not_yet_q;
	logic            roll_q;
	logic [TS_W-1:0] elapsed_q;
	logic [TS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW:0]     total_sum_q;
	logic [AW:0]     period_sum_q;
	logic [TS_W-1:0] start_new_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [TS_W-1:0]     out_total_q;
	logic [TS_W-1:0]     out_period_q;

	logic in_acc;
	logic cfg_acc;
	logic out_free;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - STATUS_W - 2 * TS_W){1'b0}},
		out_period_q, out_total_q, out_status_q};

	// scope and unmetered tests
	logic scope_bad;
	logic unmet_bad;
	assign scope_bad = (mod_q >= MOD_W'(TS_W)) || !module_mask_q[mod_q[CNT_W-1:0]];
	assign unmet_bad = (max_per_act_q != '0) || (max_total_q != '0) ||
		(max_per_per_q != '0) || (spent_total_q != '0) ||
		(spent_period_q != '0) || (period_len_q != '0);

	// elapsed time with borrow
	logic [TS_W:0] elapsed_diff;
	assign elapsed_diff = {1'b0, now_q} - {1'b0, period_start_q};

	// shared restoring remainder step
	logic [TS_W:0] div_shift;
	logic [TS_W:0] div_sub;
	assign div_shift = {rem_q, elapsed_q[TS_W-1]};
	assign div_sub   = div_shift - {1'b0, period_len_q};

	// final cap tests, in priority order
	logic [STATUS_W-1:0] fin_status;
	logic                fin_commit;
	always_comb begin
		fin_commit = 1'b0;
		priority if (decided_q) begin
			fin_status = status_q;
		end else if (TS_W'(amount_q) > max_per_act_q) begin
			fin_status = ST_EXHAUSTED;
		end else if (total_sum_q[AW]) begin
			fin_status = ST_OVERFLOW;
		end else if ((max_total_q != '0) && (TS_W'(total_sum_q[AW-1:0]) > max_total_q)) begin
			fin_status = ST_EXHAUSTED;
		end else if (period_sum_q[AW]) begin
			fin_status = ST_OVERFLOW;
		end else if ((period_len_q != '0) &&
			(TS_W'(period_sum_q[AW-1:0]) > max_per_per_q)) begin
			fin_status = ST_EXHAUSTED;
		end else begin
			fin_status = ST_OK;
			fin_commit = 1'b1;
		end
	end

	logic do_commit;
	assign do_commit = (state_q == S_FIN) && out_free && fin_commit && action_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_SCOPE;
				end
				S_SCOPE: begin
					if (scope_bad || !metered_q) state_q <= S_FIN;
					else state_q <= S_ROLLCHK;
				end
				S_ROLLCHK: begin
					priority if (period_len_q == '0) begin
						state_q <= S_SUM;
					end else if (not_yet_q) begin
						state_q <= S_FIN;
					end else if (elapsed_q >= period_len_q) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TS_W - 1)) state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					action_q  <= s_tuser;
					mod_q     <= s_tdata[MOD_W-1:0];
					amount_q  <= AW'(s_tdata[MOD_W + TS_W - 1:MOD_W]);
					now_q     <= s_tdata[MOD_W + 2 * TS_W - 1:MOD_W + TS_W];
					decided_q <= 1'b0;
					roll_q    <= 1'b0;
				end
			end
			S_SCOPE: begin
				elapsed_q   <= elapsed_diff[TS_W-1:0];
				not_yet_q   <= elapsed_diff[TS_W];
				start_new_q <= period_start_q;
				if (scope_bad) begin
					decided_q <= 1'b1;
					status_q  <= ST_SCOPE;
				end else if (!metered_q) begin
					decided_q <= 1'b1;
					status_q  <= unmet_bad ? ST_SCOPE : ST_OK;
				end
			end
			S_ROLLCHK: begin
				rem_q <= '0;
				if ((period_len_q != '0) && not_yet_q) begin
					decided_q <= 1'b1;
					status_q  <= ST_NOT_YET;
				end
			end
			S_DIV: begin
				// one remainder bit per cycle
				if (!div_sub[TS_W]) rem_q <= div_sub[TS_W-1:0];
				else rem_q <= div_shift[TS_W-1:0];
				elapsed_q <= elapsed_q << 1;
				if (cnt_q == CNT_W'(TS_W - 1)) roll_q <= 1'b1;
			end
			S_SUM: begin
				total_sum_q  <= {1'b0, spent_total_q} + {1'b0, amount_q};
				period_sum_q <= (roll_q ? {(AW + 1){1'b0}} : {1'b0, spent_period_q}) +
					{1'b0, amount_q};
				// whole periods rolled: new start is now minus the remainder
				if (roll_q) start_new_q <= now_q - rem_q;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// configuration and metering state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_mask_q  <= '0;
			metered_q      <= 1'b0;
			max_per_act_q  <= '0;
			max_total_q    <= '0;
			max_per_per_q  <= '0;
			period_len_q   <= '0;
			spent_total_q  <= '0;
			spent_period_q <= '0;
			period_start_q <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_MODULE_MASK:   module_mask_q  <= cfg_data;
					REG_METERED:       metered_q      <= cfg_data[0];
					REG_MAX_PER_ACT:   max_per_act_q  <= cfg_data;
					REG_MAX_TOTAL:     max_total_q    <= cfg_data;
					REG_MAX_PER_PER:   max_per_per_q  <= cfg_data;
					REG_PERIOD_LEN:    period_len_q   <= cfg_data;
					REG_PERIOD_ORIGIN: period_start_q <= cfg_data;
					default: begin
					end
				endcase
			end else if (do_commit) begin
				spent_total_q  <= total_sum_q[AW-1:0];
				spent_period_q <= period_sum_q[AW-1:0];
				period_start_q <= start_new_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			out_status_q <= fin_status;
			out_total_q  <= do_commit ? TS_W'(total_sum_q[AW-1:0]) : TS_W'(spent_total_q);
			out_period_q <= do_commit ? TS_W'(period_sum_q[AW-1:0]) : TS_W'(spent_period_q);
		end
	end

endmodule

// ===== hw/rtl/psqm_checker.sv =====
// Port-level checker for the periodic spend quota meter, with its bind.
// Uses psqm_pkg for packing widths and status codes.
module psqm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	// status[2:0], spent_total_now[66:3], spent_period_now[130:67]
	input logic [psqm_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import psqm_pkg::*;

	logic [TS_W-1:0] res_total;
	logic [TS_W-1:0] res_period;
	logic [TS_W-1:0] last_total_q;

	assign res_total  = m_tdata[STATUS_W + TS_W - 1:STATUS_W];
	assign res_period = m_tdata[STATUS_W + 2 * TS_W - 1:STATUS_W + TS_W];

	// lifetime spend of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_total_q <= res_total;
		end
	end

	// one request at a time: no request taken right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// lifetime spend never goes down
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |-> (res_total >= last_total_q))
		else $error("lifetime spend decreased");

	// period spend is part of lifetime spend
	a_period_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_period <= res_total))
		else $error("period spend exceeds lifetime spend");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind periodic_spend_quota_meter psqm_checker u_psqm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
